// File: src/assert_macros.svh
// assertion helper macros shared by the firing unit rtl
// no dependencies; bodies drop out when SYNTHESIS is defined
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// expression must hold at every clock edge out of reset
`define ASSERT_ALWAYS(lbl, clk, rst, expr) \
  lbl: assert property (@(posedge clk) disable iff (rst) (expr)) \
    else $error("assertion failed");
// consequent must hold in the same cycle as the antecedent
`define ASSERT_IMPLIES(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");
// consequent must hold in the cycle after the antecedent
`define ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define ASSERT_ALWAYS(lbl, clk, rst, expr)
`define ASSERT_IMPLIES(lbl, clk, rst, ante, cons)
`define ASSERT_NEXT(lbl, clk, rst, ante, cons)
`endif
`endif

// File: src/tpaf_pkg.sv
// shared types, codes and helpers for the triac phase-angle firing unit
// no dependencies; used by tpaf_cfg, tpaf_core and the top level
`timescale 1ns / 1ps
`default_nettype none

package tpaf_pkg;

  localparam int REG_W           = 16;
  localparam int COUNT_WIDTH_DEF = 16;
  localparam int CMD_W           = 3;
  localparam int REQ_W           = 17;
  localparam int CFG_IDX_W       = 3;

  // register defaults after reset
  localparam logic [REG_W-1:0] DELAY_MAX_RST      = 16'd50000;
  localparam logic [REG_W-1:0] DELAY_PRESCALE_RST = 16'd0;
  localparam logic [REG_W-1:0] PWM_PRESCALE_RST   = 16'd10;
  localparam logic [REG_W-1:0] PWM_PERIOD_RST     = 16'd600;
  localparam logic [REG_W-1:0] PWM_HIGH_RST       = 16'd70;
  localparam logic             START_LEVEL_RST    = 1'b1;

  // run start backs the trigger delay off the half-cycle length by this much
  localparam logic [REG_W+1:0] RUN_START_MARGIN = 18'd200;

  typedef enum logic [CMD_W-1:0] {
    CMD_TICK      = 3'd0,
    CMD_EDGE      = 3'd1,
    CMD_SET_DELAY = 3'd2,
    CMD_RUN_START = 3'd3,
    CMD_RUN_STOP  = 3'd4
  } cmd_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_DELAY_MAX      = 3'd0,
    REG_DELAY_PRESCALE = 3'd1,
    REG_PWM_PRESCALE   = 3'd2,
    REG_PWM_PERIOD     = 3'd3,
    REG_PWM_HIGH       = 3'd4,
    REG_START_LEVEL    = 3'd5
  } cfg_idx_e;

  typedef struct packed {
    logic [REG_W-1:0] delay_max;
    logic [REG_W-1:0] delay_prescale;
    logic [REG_W-1:0] pwm_prescale;
    logic [REG_W-1:0] pwm_period;
    logic [REG_W-1:0] pwm_high;
    logic             start_level;
  } cfg_t;

  typedef struct packed {
    logic             gate_out;
    logic             burst_active;
    logic             delay_active;
    logic             stop_active;
    logic             detector_on;
    logic [REG_W-1:0] delay_now;
  } result_t;

  // limit a requested delay to 1 .. delay_max-1
  function automatic logic [REG_W-1:0] clamp_delay(input logic signed [REG_W+1:0] req,
                                                   input logic [REG_W-1:0] dmax);
    logic signed [REG_W+1:0] lim;
    lim = $signed({2'b00, dmax});
    if (req < lim) begin
      return (req > 18'sd0) ? req[REG_W-1:0] : 16'd1;
    end else begin
      return (dmax > 16'd1) ? dmax - 16'd1 : 16'd1;
    end
  endfunction

endpackage

`default_nettype wire

// File: src/tpaf_cfg.sv
// configuration register file of the firing unit
// depends on tpaf_pkg for the register codes and the cfg_t bundle
`timescale 1ns / 1ps
`default_nettype none

module tpaf_cfg (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           cfg_we,
  input  wire logic [tpaf_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [tpaf_pkg::REG_W-1:0]     cfg_data,
  output tpaf_pkg::cfg_t                      cfg
);

  tpaf_pkg::cfg_t regs;

  always_ff @(posedge clk) begin
    if (rst) begin
      regs.delay_max      <= tpaf_pkg::DELAY_MAX_RST;
      regs.delay_prescale <= tpaf_pkg::DELAY_PRESCALE_RST;
      regs.pwm_prescale   <= tpaf_pkg::PWM_PRESCALE_RST;
      regs.pwm_period     <= tpaf_pkg::PWM_PERIOD_RST;
      regs.pwm_high       <= tpaf_pkg::PWM_HIGH_RST;
      regs.start_level    <= tpaf_pkg::START_LEVEL_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        tpaf_pkg::REG_DELAY_MAX:      regs.delay_max      <= cfg_data;
        tpaf_pkg::REG_DELAY_PRESCALE: regs.delay_prescale <= cfg_data;
        tpaf_pkg::REG_PWM_PRESCALE:   regs.pwm_prescale   <= cfg_data;
        tpaf_pkg::REG_PWM_PERIOD:     regs.pwm_period     <= cfg_data;
        tpaf_pkg::REG_PWM_HIGH:       regs.pwm_high       <= cfg_data;
        tpaf_pkg::REG_START_LEVEL:    regs.start_level    <= cfg_data[0];
        default: ;
      endcase
    end
  end

  assign cfg = regs;

endmodule

`default_nettype wire

// File: src/tpaf_core.sv
// firing state and its single-pass update for one command
// depends on tpaf_pkg and assert_macros.svh
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module tpaf_core #(
  parameter int COUNT_WIDTH = tpaf_pkg::COUNT_WIDTH_DEF
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire tpaf_pkg::cfg_t               cfg,
  input  wire logic                         step,
  input  wire logic [tpaf_pkg::CMD_W-1:0]   cmd,
  input  wire logic                         pin_level,
  input  wire logic [tpaf_pkg::REQ_W-1:0]   delay_request,
  output tpaf_pkg::result_t                 res_next
);

  localparam int RW    = tpaf_pkg::REG_W;
  localparam int CMP_W = (COUNT_WIDTH > RW) ? COUNT_WIDTH : RW;

  logic [RW-1:0]          trigger_delay, trigger_delay_next;
  logic [RW-1:0]          delay_count, delay_count_next;
  logic [RW-1:0]          stop_count, stop_count_next;
  logic [COUNT_WIDTH-1:0] pwm_count, pwm_count_next;
  logic [COUNT_WIDTH-1:0] slow_pcnt, slow_pcnt_next;
  logic [COUNT_WIDTH-1:0] pwm_pcnt, pwm_pcnt_next;
  logic delay_on, delay_on_next;
  logic stop_on, stop_on_next;
  logic burst_on, burst_on_next;
  logic detect_en, detect_en_next;

  logic slow_step, pwm_step, delay_exp, stop_exp;
  logic signed [RW+1:0] req_ext, start_req;

  assign req_ext   = $signed({delay_request[tpaf_pkg::REQ_W-1], delay_request});
  assign start_req = $signed({2'b00, cfg.delay_max}) - $signed(tpaf_pkg::RUN_START_MARGIN);

  always_comb begin
    trigger_delay_next = trigger_delay;
    delay_count_next   = delay_count;
    stop_count_next    = stop_count;
    pwm_count_next     = pwm_count;
    slow_pcnt_next     = slow_pcnt;
    pwm_pcnt_next      = pwm_pcnt;
    delay_on_next      = delay_on;
    stop_on_next       = stop_on;
    burst_on_next      = burst_on;
    detect_en_next     = detect_en;
    slow_step          = 1'b0;
    pwm_step           = 1'b0;
    delay_exp          = 1'b0;
    stop_exp           = 1'b0;

    unique case (cmd)
      tpaf_pkg::CMD_TICK: begin
        // shared prescaler of the delay and stop counters
        if (delay_on || stop_on) begin
          if (CMP_W'(slow_pcnt) >= CMP_W'(cfg.delay_prescale)) begin
            slow_pcnt_next = '0;
            slow_step      = 1'b1;
          end else begin
            slow_pcnt_next = slow_pcnt + COUNT_WIDTH'(1);
          end
        end
        if (burst_on) begin
          if (CMP_W'(pwm_pcnt) >= CMP_W'(cfg.pwm_prescale)) begin
            pwm_pcnt_next = '0;
            pwm_step      = 1'b1;
          end else begin
            pwm_pcnt_next = pwm_pcnt + COUNT_WIDTH'(1);
          end
        end
        if (pwm_step) begin
          pwm_count_next = (CMP_W'(pwm_count) >= CMP_W'(cfg.pwm_period)) ? '0
                         : pwm_count + COUNT_WIDTH'(1);
        end
        if (slow_step && delay_on) begin
          if (delay_count == '0) delay_exp = 1'b1;
          else delay_count_next = delay_count - 16'd1;
        end
        if (slow_step && stop_on) begin
          if (stop_count == '0) stop_exp = 1'b1;
          else stop_count_next = stop_count - 16'd1;
        end
        if (delay_exp) begin
          delay_on_next = 1'b0;
          burst_on_next = 1'b1;
          pwm_pcnt_next = '0;
        end
        // stop expiry wins over a burst start on the same tick
        if (stop_exp) begin
          delay_on_next = 1'b0;
          burst_on_next = 1'b0;
          stop_on_next  = 1'b0;
        end
      end
      tpaf_pkg::CMD_EDGE: begin
        if (detect_en) begin
          burst_on_next = 1'b0;
          if (pin_level == cfg.start_level) begin
            stop_count_next  = cfg.delay_max;
            stop_on_next     = 1'b1;
            delay_count_next = trigger_delay;
            delay_on_next    = 1'b1;
            slow_pcnt_next   = '0;
          end else begin
            delay_on_next = 1'b0;
          end
        end
      end
      tpaf_pkg::CMD_SET_DELAY: begin
        trigger_delay_next = tpaf_pkg::clamp_delay(req_ext, cfg.delay_max);
      end
      tpaf_pkg::CMD_RUN_START: begin
        trigger_delay_next = tpaf_pkg::clamp_delay(start_req, cfg.delay_max);
        detect_en_next     = 1'b1;
      end
      tpaf_pkg::CMD_RUN_STOP: begin
        detect_en_next = 1'b0;
        delay_on_next  = 1'b0;
        burst_on_next  = 1'b0;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      trigger_delay <= tpaf_pkg::DELAY_MAX_RST;
      delay_count   <= '0;
      stop_count    <= '0;
      pwm_count     <= '0;
      slow_pcnt     <= '0;
      pwm_pcnt      <= '0;
      delay_on      <= 1'b0;
      stop_on       <= 1'b0;
      burst_on      <= 1'b0;
      detect_en     <= 1'b0;
    end else if (step) begin
      trigger_delay <= trigger_delay_next;
      delay_count   <= delay_count_next;
      stop_count    <= stop_count_next;
      pwm_count     <= pwm_count_next;
      slow_pcnt     <= slow_pcnt_next;
      pwm_pcnt      <= pwm_pcnt_next;
      delay_on      <= delay_on_next;
      stop_on       <= stop_on_next;
      burst_on      <= burst_on_next;
      detect_en     <= detect_en_next;
    end
  end

  always_comb begin
    res_next.gate_out     = burst_on_next &&
                            (CMP_W'(pwm_count_next) < CMP_W'(cfg.pwm_high));
    res_next.burst_active = burst_on_next;
    res_next.delay_active = delay_on_next;
    res_next.stop_active  = stop_on_next;
    res_next.detector_on  = detect_en_next;
    res_next.delay_now    = trigger_delay_next;
  end

  // delay phase and gate burst never overlap
  `ASSERT_ALWAYS(a_delay_burst_excl, clk, rst, !(delay_on && burst_on))
  // both firing phases live inside a running half cycle
  `ASSERT_IMPLIES(a_phase_in_half, clk, rst, delay_on || burst_on, stop_on)
  // the trigger delay is never zero
  `ASSERT_ALWAYS(a_delay_nonzero, clk, rst, trigger_delay != '0)

endmodule

`default_nettype wire

// File: src/triac_phase_angle_firing_unit.sv
// triac phase-angle firing unit top level: stream ports, input and result registers
// depends on tpaf_pkg, tpaf_cfg, tpaf_core and assert_macros.svh
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

// a beat taken on s_* waits in the input register until the result register is free
//   or being drained, is then processed into it and is offered on m_* from then on
// throughput: one beat per cycle unless m_* stalls; one single-pass state update per beat
// reset: synchronous, active high; registers take their defaults, counters
//   and run flags clear, the trigger delay takes 50000, both stages empty
module triac_phase_angle_firing_unit #(
  parameter int COUNT_WIDTH = tpaf_pkg::COUNT_WIDTH_DEF
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  // command input
  input  wire logic                           s_tvalid,
  output      logic                           s_tready,
  input  wire logic [23:0]                    s_tdata,   // pin_level[0], delay_request[17:1],
                                                         // zero
  input  wire logic [tpaf_pkg::CMD_W-1:0]     s_tuser,   // cmd[2:0]
  // result output
  output      logic                           m_tvalid,
  input  wire logic                           m_tready,
  output      logic [23:0]                    m_tdata,   // gate_out[0], burst_active[1],
                                                         // delay_active[2], stop_active[3],
                                                         // detector_on[4], delay_now[20:5]
  // configuration writes
  input  wire logic                           cfg_we,
  input  wire logic [tpaf_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [tpaf_pkg::REG_W-1:0]     cfg_data
);

  tpaf_pkg::cfg_t    cfg;
  tpaf_pkg::result_t res_next;
  tpaf_pkg::result_t out_res;

  // input register
  logic                         in_valid;
  logic [tpaf_pkg::CMD_W-1:0]   in_cmd;
  logic                         in_pin;
  logic [tpaf_pkg::REQ_W-1:0]   in_req;

  logic out_valid;
  logic advance;

  // the held beat moves on when the result register is free or being drained
  assign advance  = in_valid && (!out_valid || m_tready);
  assign s_tready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_cmd <= s_tuser;
      in_pin <= s_tdata[0];
      in_req <= s_tdata[17:1];
    end
  end

  tpaf_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  tpaf_core #(
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_core (
    .clk           (clk),
    .rst           (rst),
    .cfg           (cfg),
    .step          (advance),
    .cmd           (in_cmd),
    .pin_level     (in_pin),
    .delay_request (in_req),
    .res_next      (res_next)
  );

  // result register: holds a beat while the sink stalls
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_res <= res_next;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {3'b000, out_res.delay_now, out_res.detector_on, out_res.stop_active,
                     out_res.delay_active, out_res.burst_active, out_res.gate_out};

  // a processed beat always lands in the result register
  `ASSERT_NEXT(a_advance_fills, clk, rst, advance, out_valid)
  // a stalled result blocks the input stage from moving
  `ASSERT_IMPLIES(a_no_overwrite, clk, rst, out_valid && !m_tready, !advance)
  // the gate only drives during a burst
  `ASSERT_IMPLIES(a_gate_in_burst, clk, rst, out_valid && out_res.gate_out,
                  out_res.burst_active)

endmodule

`default_nettype wire
